[rtl/matrix_inverse_3x3_macros.svh]
// Assertion macros shared by the matrix inverse RTL.
// Each macro expects clk and rst_n to be visible in the including scope.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_NOW(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

[rtl/mi3_pkg.sv]
// Shared types, constants and width helpers for the 3x3 matrix inverse.
// No dependencies; every file of the block but the macros header imports this package.
package mi3_pkg;

    // Width of the singular threshold register.
    localparam int unsigned ThrW = 31;

    // Reset value of the singular threshold.
    localparam logic [ThrW-1:0] ThrReset = ThrW'(1);

    // Operand indexes of each adjugate element: adj = e[a]*e[b] - e[c]*e[d].
    localparam logic [3:0] CofIdx [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Control that travels with each beat from the determinant stages onward.
    typedef struct packed {
        logic valid;
        logic singular;
    } ctl_t;

    // Width of the rounding numerator |adj| * 2^(2F+1) + |det|.
    function automatic int mi3_num_w(int w, int f);
        int a;
        int b;
        a = 2 * w + 2 * f + 1;
        b = 3 * w;
        return ((a > b) ? a : b) + 1;
    endfunction

    // Working width of the divider remainder, with one spare sign bit.
    function automatic int mi3_ext_w(int w, int f);
        int n;
        int d;
        n = mi3_num_w(w, f);
        d = 4 * w + 1;
        return ((n > d) ? n : d) + 1;
    endfunction

    // Width of the threshold compare against |det|.
    function automatic int mi3_thr_w(int w, int f);
        int a;
        int b;
        a = 3 * w;
        b = ThrW + 2 * f;
        return (a > b) ? a : b;
    endfunction

endpackage

[rtl/mi3_if.sv]
// Channel interfaces of the matrix inverse: matrix in, inverse out, threshold write.
// Depends on mi3_pkg for the threshold width.
interface mi3_mat_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] e00;
    logic signed [W-1:0] e01;
    logic signed [W-1:0] e02;
    logic signed [W-1:0] e10;
    logic signed [W-1:0] e11;
    logic signed [W-1:0] e12;
    logic signed [W-1:0] e20;
    logic signed [W-1:0] e21;
    logic signed [W-1:0] e22;

    modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                    input ready);
    modport sink (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

interface mi3_inv_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] r00;
    logic signed [W-1:0] r01;
    logic signed [W-1:0] r02;
    logic signed [W-1:0] r10;
    logic signed [W-1:0] r11;
    logic signed [W-1:0] r12;
    logic signed [W-1:0] r20;
    logic signed [W-1:0] r21;
    logic signed [W-1:0] r22;
    logic                singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                    input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular,
                  output ready);
endinterface

interface mi3_cfg_if;
    import mi3_pkg::*;
    logic            valid;
    logic            ready;
    logic [ThrW-1:0] singular_threshold;

    modport source (output valid, singular_threshold, input ready);
    modport sink (input valid, singular_threshold, output ready);
endinterface

[rtl/mi3_cof.sv]
// Adjugate stages: eighteen element products, then nine 2x2 cofactor differences.
// Depends on mi3_pkg for the cofactor index table.
module mi3_cof #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   e [9],
    output logic                  out_valid,
    output logic signed [2*W-1:0] adj [9],
    output logic signed [W-1:0]   e_top [3]
);
    import mi3_pkg::*;

    logic [1:0]            v_reg;
    logic signed [2*W-1:0] prod_reg [18];
    logic signed [2*W-1:0] prod_next [18];
    logic signed [W-1:0]   ea_reg [3];
    logic signed [2*W-1:0] adj_reg [9];
    logic signed [W-1:0]   eb_reg [3];

    // Both products of every cofactor.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_next[2*k]   = e[CofIdx[k][0]] * e[CofIdx[k][1]];
            prod_next[2*k+1] = e[CofIdx[k][2]] * e[CofIdx[k][3]];
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[0], in_valid};
    end

    // Product stage, then difference stage; the top row rides along for the determinant.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 18; k++)
                prod_reg[k] <= prod_next[k];
            for (int j = 0; j < 3; j++)
            begin
                ea_reg[j] <= e[j];
                eb_reg[j] <= ea_reg[j];
            end
            for (int k = 0; k < 9; k++)
                adj_reg[k] <= prod_reg[2*k] - prod_reg[2*k+1];
        end
    end

    assign out_valid = v_reg[1];
    assign adj       = adj_reg;
    assign e_top     = eb_reg;
endmodule

[rtl/mi3_det.sv]
// Determinant stages: split products along the top row, their sum, magnitudes,
// the singular test and the rounding numerators. Depends on mi3_pkg.
module mi3_det #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [2*W-1:0]           adj [9],
    input  logic signed [W-1:0]             e_top [3],
    input  logic [mi3_pkg::ThrW-1:0]        thr,
    output mi3_pkg::ctl_t                   ctl,
    output logic [mi3_pkg::mi3_ext_w(W, F)-1:0] num [9],
    output logic [3*W:0]                    den,
    output logic                            neg [9]
);
    import mi3_pkg::*;

    localparam int DTW = 3 * W + 1;
    localparam int MW  = 3 * W;
    localparam int XW  = mi3_ext_w(W, F);
    localparam int TW  = mi3_thr_w(W, F);

    logic [4:0]            v_reg;
    logic signed [2*W-1:0] hi_reg [3];
    logic signed [2*W:0]   lo_reg [3];
    logic signed [DTW-1:0] term_reg [3];
    logic signed [DTW-1:0] det_reg;
    logic                  det_neg_reg;
    logic [MW-1:0]         det_mag_reg;
    logic signed [2*W-1:0] adj_c_reg [9];
    logic signed [2*W-1:0] adj_d_reg [9];
    logic signed [2*W-1:0] adj_e_reg [9];
    logic                  adj_neg_reg [9];
    logic [2*W-1:0]        adj_mag_reg [9];
    logic                  sing_reg;
    logic [XW-1:0]         num_reg [9];
    logic [MW:0]           den_reg;
    logic                  neg_reg [9];
    logic                  sing_next;

    // Singular when the determinant is zero or below the threshold at Q(3F) scale.
    assign sing_next = (det_mag_reg == '0) ||
                       (TW'(det_mag_reg) < (TW'(thr) << (2 * F)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Top-row element times cofactor, cut into high and low halves.
            for (int j = 0; j < 3; j++)
            begin
                hi_reg[j] <= e_top[j] * $signed(adj[3*j][2*W-1:W]);
                lo_reg[j] <= e_top[j] * $signed({1'b0, adj[3*j][W-1:0]});
            end
            // Recombine the halves into full terms.
            for (int j = 0; j < 3; j++)
                term_reg[j] <= (DTW'(hi_reg[j]) <<< W) + DTW'(lo_reg[j]);
            // Determinant.
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            // Sign and magnitude of the determinant and of every cofactor.
            det_neg_reg <= det_reg[DTW-1];
            det_mag_reg <= det_reg[DTW-1] ? MW'(-det_reg) : MW'(det_reg);
            for (int k = 0; k < 9; k++)
            begin
                adj_c_reg[k]   <= adj[k];
                adj_d_reg[k]   <= adj_c_reg[k];
                adj_e_reg[k]   <= adj_d_reg[k];
                adj_neg_reg[k] <= adj_e_reg[k][2*W-1];
                adj_mag_reg[k] <= adj_e_reg[k][2*W-1] ? (2*W)'(-adj_e_reg[k])
                                                      : (2*W)'(adj_e_reg[k]);
            end
            // Rounding numerators and the doubled divisor.
            sing_reg <= sing_next;
            den_reg  <= {det_mag_reg, 1'b0};
            for (int k = 0; k < 9; k++)
            begin
                num_reg[k] <= (XW'(adj_mag_reg[k]) << (2 * F + 1)) + XW'(det_mag_reg);
                neg_reg[k] <= adj_neg_reg[k] ^ det_neg_reg;
            end
        end
    end

    assign ctl.valid    = v_reg[4];
    assign ctl.singular = sing_reg;
    assign num          = num_reg;
    assign den          = den_reg;
    assign neg          = neg_reg;
endmodule

[rtl/mi3_div.sv]
// Pipelined restoring divider for the nine lanes, one quotient bit per stage,
// followed by saturation, sign and the identity substitution. Depends on mi3_pkg.
module mi3_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  mi3_pkg::ctl_t                   ctl_in,
    input  logic [mi3_pkg::mi3_ext_w(W, F)-1:0] num [9],
    input  logic [3*W:0]                    den,
    input  logic                            neg [9],
    output mi3_pkg::ctl_t                   ctl_out,
    output logic signed [W-1:0]             res [9]
);
    import mi3_pkg::*;

    localparam int XW = mi3_ext_w(W, F);
    localparam int DW = 3 * W + 1;
    localparam logic [W-1:0] OneFix = W'(1) << F;
    localparam logic [W-1:0] MinMag = W'(1) << (W - 1);
    localparam logic [W-1:0] MaxMag = (W'(1) << (W - 1)) - W'(1);

    ctl_t            ctl_reg [W+1];
    logic [XW-1:0]   rem_reg [W+1][9];
    logic [W-1:0]    q_reg [W+1][9];
    logic            ovf_reg [W+1][9];
    logic            neg_reg [W+1][9];
    logic [DW-1:0]   den_reg [W+1];
    ctl_t            fin_ctl_reg;
    logic signed [W-1:0] fin_reg [9];
    logic [W-1:0]    lim [9];
    logic [W-1:0]    mag [9];

    // Control of every stage, reset so no stale beat emerges.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= W; s++)
                ctl_reg[s] <= '0;
            fin_ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s <= W; s++)
                ctl_reg[s] <= ctl_reg[s-1];
            fin_ctl_reg <= ctl_reg[W];
        end
    end

    // Entry stage: a quotient of 2^W or more saturates regardless of sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int k = 0; k < 9; k++)
            begin
                rem_reg[0][k] <= num[k];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= num[k] >= (XW'(den) << W);
                neg_reg[0][k] <= neg[k];
            end
        end
    end

    // One compare and subtract per stage, most significant quotient bit first.
    for (genvar i = 1; i <= W; i++)
    begin : g_step
        logic [XW-1:0] trial [9];

        always_comb
        begin
            for (int k = 0; k < 9; k++)
                trial[k] = rem_reg[i-1][k] - (XW'(den_reg[i-1]) << (W - i));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i] <= den_reg[i-1];
                for (int k = 0; k < 9; k++)
                begin
                    rem_reg[i][k] <= trial[k][XW-1] ? rem_reg[i-1][k] : trial[k];
                    q_reg[i][k]   <= q_reg[i-1][k] |
                                     (W'(!trial[k][XW-1]) << (W - i));
                    ovf_reg[i][k] <= ovf_reg[i-1][k];
                    neg_reg[i][k] <= neg_reg[i-1][k];
                end
            end
        end
    end

    // Clamp to the signed range, then apply the sign.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            lim[k] = neg_reg[W][k] ? MinMag : MaxMag;
            mag[k] = (ovf_reg[W][k] || (q_reg[W][k] > lim[k])) ? lim[k] : q_reg[W][k];
        end
    end

    // Final stage: identity for a singular matrix.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (ctl_reg[W].singular)
                    fin_reg[k] <= ((k % 4) == 0) ? OneFix : '0;
                else
                    fin_reg[k] <= neg_reg[W][k] ? -mag[k] : mag[k];
            end
        end
    end

    assign ctl_out = fin_ctl_reg;
    assign res     = fin_reg;
endmodule

[rtl/matrix_inverse_3x3.sv]
// Channel     Direction  Payload
// mat         in         e00..e22, signed Q(FRAC_BITS), DATA_WIDTH bits each
// inv         out        r00..r22 inverse, saturated, plus singular flag
// cfg         in         singular_threshold, 31 bits, Q(FRAC_BITS)
//
// One matrix is accepted per cycle while mat.ready is high, the pipeline depth being set
// by the one-bit-per-stage divider.
// rst_n clears all valid bits and sets the threshold to 1; no clearing pass.
// A stall on inv fills a one-beat skid stage; mat.ready drops only once it is full,
// and then the whole pipeline holds with nothing lost or repeated.
// Depends on mi3_pkg, mi3_if, mi3_cof, mi3_det, mi3_div and the macros header.
module matrix_inverse_3x3 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic     clk,
    input logic     rst_n,
    mi3_mat_if.sink mat,
    mi3_inv_if.source inv,
    mi3_cfg_if.sink cfg
);
    import mi3_pkg::*;
    `include "matrix_inverse_3x3_macros.svh"

    localparam int W  = DATA_WIDTH;
    localparam int XW = mi3_ext_w(DATA_WIDTH, FRAC_BITS);
    localparam logic [W-1:0] OneFix = W'(1) << FRAC_BITS;

    logic [ThrW-1:0]       thr_reg;
    logic                  adv;
    logic signed [W-1:0]   e_in [9];
    logic                  cof_valid;
    logic signed [2*W-1:0] cof_adj [9];
    logic signed [W-1:0]   cof_top [3];
    ctl_t                  det_ctl;
    logic [XW-1:0]         det_num [9];
    logic [3*W:0]          det_den;
    logic                  det_neg [9];
    ctl_t                  div_ctl;
    logic signed [W-1:0]   div_res [9];
    logic                  push;
    logic                  out_free;
    logic                  out_valid_reg;
    logic signed [W-1:0]   out_res_reg [9];
    logic                  out_sing_reg;
    logic                  skid_valid_reg;
    logic signed [W-1:0]   skid_res_reg [9];
    logic                  skid_sing_reg;

    // Threshold register; always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= ThrReset;
        else if (cfg.valid)
            thr_reg <= cfg.singular_threshold;
    end

    // The pipeline advances whenever the skid stage is empty.
    assign adv       = !skid_valid_reg;
    assign mat.ready = adv;

    assign e_in[0] = mat.e00;
    assign e_in[1] = mat.e01;
    assign e_in[2] = mat.e02;
    assign e_in[3] = mat.e10;
    assign e_in[4] = mat.e11;
    assign e_in[5] = mat.e12;
    assign e_in[6] = mat.e20;
    assign e_in[7] = mat.e21;
    assign e_in[8] = mat.e22;

    mi3_cof #(.W(W)) u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mat.valid),
        .e         (e_in),
        .out_valid (cof_valid),
        .adj       (cof_adj),
        .e_top     (cof_top)
    );

    mi3_det #(.W(W), .F(FRAC_BITS)) u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (cof_valid),
        .adj      (cof_adj),
        .e_top    (cof_top),
        .thr      (thr_reg),
        .ctl      (det_ctl),
        .num      (det_num),
        .den      (det_den),
        .neg      (det_neg)
    );

    mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .ctl_in  (det_ctl),
        .num     (det_num),
        .den     (det_den),
        .neg     (det_neg),
        .ctl_out (div_ctl),
        .res     (div_res)
    );

    // Output register with a one-beat skid stage behind it.
    assign push     = adv && div_ctl.valid;
    assign out_free = inv.ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_res_reg  <= skid_res_reg;
                out_sing_reg <= skid_sing_reg;
            end
            else
            begin
                out_res_reg  <= div_res;
                out_sing_reg <= div_ctl.singular;
            end
        end
        else if (push)
        begin
            skid_res_reg  <= div_res;
            skid_sing_reg <= div_ctl.singular;
        end
    end

    assign inv.valid    = out_valid_reg;
    assign inv.r00      = out_res_reg[0];
    assign inv.r01      = out_res_reg[1];
    assign inv.r02      = out_res_reg[2];
    assign inv.r10      = out_res_reg[3];
    assign inv.r11      = out_res_reg[4];
    assign inv.r12      = out_res_reg[5];
    assign inv.r20      = out_res_reg[6];
    assign inv.r21      = out_res_reg[7];
    assign inv.r22      = out_res_reg[8];
    assign inv.singular = out_sing_reg;

    // A full skid stage always sits behind a full output register.
    `MI3_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full while output empty")
    // The skid stage fills only while the output beat is held.
    `MI3_ASSERT_NOW(a_skid_on_stall, $rose(skid_valid_reg), $past(out_valid_reg && !inv.ready), "skid filled without a stall")
    // A singular beat carries the identity.
    `MI3_ASSERT_NOW(a_singular_ident, out_valid_reg && out_sing_reg, out_res_reg[0] == OneFix && out_res_reg[4] == OneFix && out_res_reg[8] == OneFix && out_res_reg[1] == '0 && out_res_reg[5] == '0, "singular beat is not the identity")
endmodule

[tb/matrix_inverse_3x3_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for matrix_inverse_3x3: matrices go in, and each inverse is
// checked against an exact wide-integer adjugate/determinant computation.
// Depends on mi3_pkg, the mi3_if channel interfaces and the matrix_inverse_3x3 RTL.
module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    typedef logic signed [31:0] elem_t;
    typedef logic signed [255:0] wide_t;

    typedef struct {
        elem_t e[9];
    } matrix_t;

    typedef struct {
        elem_t r[9];
        logic  singular;
    } inverse_t;

    logic clk;
    logic rst_n;

    mi3_mat_if #(32) mat_ch ();
    mi3_inv_if #(32) inv_ch ();
    mi3_cfg_if       cfg_ch ();

    matrix_inverse_3x3 #(.DATA_WIDTH(32), .FRAC_BITS(16)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_ch),
        .inv   (inv_ch),
        .cfg   (cfg_ch)
    );

    inverse_t        pending_inverses[$];
    logic [ThrW-1:0] threshold;
    int              fail_count;
    int              idle_pct;
    int              stall_pct;
    int              quiet_cycles;

    localparam int QuietLimit = 5000;
    localparam elem_t One     = 32'sh0001_0000;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round |adj| * 2^32 / |det| to nearest, ties away from zero, then saturate.
    function automatic elem_t scaled_quotient(wide_t adj, wide_t det);
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] quo;
        logic [255:0] lim;
        logic         neg;
        neg = (adj < 0) != (det < 0);
        num = ((adj < 0 ? -adj : adj) << 33) + (det < 0 ? -det : det);
        den = (det < 0 ? -det : det) << 1;
        quo = num / den;
        if (quo == 0)
            return '0;
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (quo > lim)
            quo = lim;
        return neg ? elem_t'(-quo) : elem_t'(quo);
    endfunction

    // Exact inverse of one matrix under the current threshold.
    function automatic inverse_t invert_matrix(matrix_t m, logic [ThrW-1:0] thr);
        wide_t    e[9];
        wide_t    adj[9];
        wide_t    det;
        wide_t    det_mag;
        wide_t    thr_scaled;
        inverse_t res;
        for (int i = 0; i < 9; i++)
            e[i] = m.e[i];
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        det_mag = det < 0 ? -det : det;
        thr_scaled = wide_t'({1'b0, thr}) << 32;
        // A zero determinant is singular even with a zero threshold.
        if (det == 0 || det_mag < thr_scaled)
        begin
            for (int i = 0; i < 9; i++)
                res.r[i] = (i % 4 == 0) ? One : '0;
            res.singular = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                res.r[i] = scaled_quotient(adj[i], det);
            res.singular = 1'b0;
        end
        return res;
    endfunction

    // Send one matrix beat, with random idle cycles in front of it.
    task automatic send_matrix(matrix_t m);
        while ($urandom_range(99) < idle_pct)
        begin
            mat_ch.valid <= 1'b0;
            @(posedge clk);
        end
        mat_ch.valid <= 1'b1;
        mat_ch.e00 <= m.e[0];
        mat_ch.e01 <= m.e[1];
        mat_ch.e02 <= m.e[2];
        mat_ch.e10 <= m.e[3];
        mat_ch.e11 <= m.e[4];
        mat_ch.e12 <= m.e[5];
        mat_ch.e20 <= m.e[6];
        mat_ch.e21 <= m.e[7];
        mat_ch.e22 <= m.e[8];
        do
            @(posedge clk);
        while (!mat_ch.ready);
        pending_inverses.push_back(invert_matrix(m, threshold));
    endtask

    // Wait until every expected inverse has arrived and the pipeline has drained.
    task automatic drain_pipeline();
        mat_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Write the threshold register while the block is idle.
    task automatic write_threshold(logic [ThrW-1:0] value);
        drain_pipeline();
        cfg_ch.valid <= 1'b1;
        cfg_ch.singular_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        threshold = value;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic matrix_t diag_matrix(elem_t a, elem_t b, elem_t c);
        matrix_t m;
        for (int i = 0; i < 9; i++)
            m.e[i] = '0;
        m.e[0] = a;
        m.e[4] = b;
        m.e[8] = c;
        return m;
    endfunction

    function automatic matrix_t fill_matrix(elem_t v);
        matrix_t m;
        for (int i = 0; i < 9; i++)
            m.e[i] = v;
        return m;
    endfunction

    // Small Q16.16 value, roughly within +-8.0.
    function automatic elem_t small_elem();
        return elem_t'(int'($urandom_range(0, 1048575)) - 524288);
    endfunction

    // Random matrix: mostly well-conditioned small values, some near-singular,
    // some diagonal, and some fully random bit patterns.
    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            m.e[i] = (kind < 2) ? elem_t'($urandom) : small_elem();
        if (kind == 6 || kind == 7)
        begin
            // Third row nearly the sum of the first two.
            for (int c = 0; c < 3; c++)
                m.e[6 + c] = m.e[c] + m.e[3 + c] + elem_t'(int'($urandom_range(0, 8)) - 4);
        end
        else if (kind == 8)
        begin
            m = diag_matrix(small_elem(), small_elem(), small_elem());
        end
        return m;
    endfunction

    // Extremes of the fields and the special cases, at the reset threshold.
    task automatic test_directed();
        matrix_t m;
        send_matrix(fill_matrix('0));
        send_matrix(diag_matrix(One, One, One));
        send_matrix(diag_matrix(-One, 2 * One, 3 * One));
        send_matrix(fill_matrix(32'sh7FFF_FFFF));
        send_matrix(fill_matrix(32'sh8000_0000));
        send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag_matrix(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
        // Determinant just at and below the reset threshold.
        send_matrix(diag_matrix(One, One, 32'sh1));
        send_matrix(diag_matrix(32'sh100, 32'sh100, 32'sh100));
        send_matrix(diag_matrix(32'sh100, 32'sh100, 32'sh0FF));
        // Tiny determinant of either sign, below the reset threshold, so singular.
        send_matrix(diag_matrix(32'sh400, 32'sh400, 32'sh40));
        send_matrix(diag_matrix(-32'sh400, 32'sh400, 32'sh40));
        // Thirds exercise rounding.
        send_matrix(diag_matrix(3 * One, -3 * One, 7 * One));
        m = diag_matrix(One, One, One);
        m.e[1] = 2 * One;
        m.e[5] = -One;
        m.e[6] = 32'sh8000;
        send_matrix(m);
        for (int i = 0; i < 9; i++)
            m.e[i] = elem_t'($urandom);
        send_matrix(m);
        drain_pipeline();
    endtask

    // Threshold extremes, including zero with a zero determinant.
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_matrix(fill_matrix('0));
        send_matrix(diag_matrix(32'sh1, 32'sh1, 32'sh1));
        send_matrix(diag_matrix(One, -One, One));
        write_threshold({ThrW{1'b1}});
        send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh100));
        send_matrix(diag_matrix(One, One, One));
        write_threshold(ThrW'(1));
    endtask

    // Random matrices under one threshold and one idling pattern.
    task automatic test_random(int count, int idle, int stall, logic [ThrW-1:0] thr);
        write_threshold(thr);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
            send_matrix(random_matrix());
        drain_pipeline();
    endtask

    // Receiver ready, stalling at the current rate.
    always @(posedge clk)
        inv_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Compare each inverse beat with the oldest expectation.
    always @(posedge clk)
    begin
        inverse_t want;
        elem_t    got[9];
        if (rst_n && inv_ch.valid && inv_ch.ready)
        begin
            got = '{inv_ch.r00, inv_ch.r01, inv_ch.r02, inv_ch.r10, inv_ch.r11,
                    inv_ch.r12, inv_ch.r20, inv_ch.r21, inv_ch.r22};
            if (pending_inverses.size() == 0)
            begin
                $display("%0t: unexpected inverse beat", $time);
                fail_count++;
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (got[i] !== want.r[i])
                    begin
                        $display("%0t: r%0d%0d expected %h actual %h", $time,
                                 i / 3, i % 3, want.r[i], got[i]);
                        fail_count++;
                    end
                end
                if (inv_ch.singular !== want.singular)
                begin
                    $display("%0t: singular expected %b actual %b", $time,
                             want.singular, inv_ch.singular);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("[matrix_inverse_3x3] ERROR");
            $finish;
        end
    end

    // Reset, then each test in turn.
    initial
    begin
        rst_n        = 1'b0;
        mat_ch.valid = 1'b0;
        mat_ch.e00   = '0;
        mat_ch.e01   = '0;
        mat_ch.e02   = '0;
        mat_ch.e10   = '0;
        mat_ch.e11   = '0;
        mat_ch.e12   = '0;
        mat_ch.e20   = '0;
        mat_ch.e21   = '0;
        mat_ch.e22   = '0;
        inv_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.singular_threshold = '0;
        threshold    = ThrReset;
        fail_count   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_random(220, 0, 0, ThrW'(1));
        test_random(220, 51, 0, ThrW'($urandom_range(0, 64)));
        test_random(220, 0, 51, ThrW'($urandom));
        test_random(240, 11, 11, ThrW'(1));

        if (fail_count == 0)
            $display("[matrix_inverse_3x3] OK");
        else
            $display("[matrix_inverse_3x3] ERROR");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_if.sv
rtl/mi3_cof.sv
rtl/mi3_det.sv
rtl/mi3_div.sv
rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_tb.sv
